[design/bptc_pkg.sv]
package bptc_pkg;

  localparam int COEF_W    = 16;
  localparam int RAW_W     = 24;
  localparam int RES_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Number of register stages from request acceptance to the result strobe.
  localparam int PIPE_LAT  = 9;

  // Internal arithmetic widths, sized for the full input and coefficient ranges.
  localparam int DT_W   = 26;
  localparam int PRD1_W = DT_W + COEF_W + 1;
  localparam int DD_W   = 2 * DT_W;
  localparam int TEMP_W = 24;
  localparam int WIDE_W = 48;
  localparam int PL_W   = RAW_W + 20;
  localparam int PH_W   = RAW_W + 1 + WIDE_W - 20;
  localparam int PROD_W = 64;

  // Temperature break points of the second-order correction, in centidegrees.
  localparam logic signed [TEMP_W-1:0] T_REF  = 24'sd2000;
  localparam logic signed [TEMP_W-1:0] T_COLD = -24'sd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TC     = 3'd2,
    REG_OFFSET_TC   = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } cfg_reg_t;

endpackage

[design/baro_pressure_temp_compensation.sv]
// Barometric pressure and temperature compensation with second-order correction.
//
// Input channel: a request carries one raw pressure conversion and one raw
// temperature conversion. It is taken at every rising edge where start is high
// and busy is low. busy never rises, so a new request may enter every cycle.
// Result channel: out_valid marks each result for exactly one cycle. Results
// leave the last pipeline stage in request order, one per request.
// Throughput is one request per cycle, set by the nine-stage multiplier
// pipeline; the downstream side cannot stall, so nothing is held.
// Configuration channel: cfg_valid/cfg_ready with cfg_index selecting one of the
// six calibration coefficients C1..C6 (indexes 0..5; other indexes are ignored)
// and cfg_data carrying its 16-bit value. cfg_ready is always high. Coefficients
// must only be changed while no request is in flight.
// Reset (rst_n low, synchronous) clears all coefficients to zero and drops every
// request that is in flight; no strobe follows for those requests.
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  output logic                     out_valid,
  output logic signed [RES_W-1:0]  out_pressure_centi_mbar,
  output logic signed [RES_W-1:0]  out_temperature_centi_deg,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  // Calibration coefficient registers.
  logic [COEF_W-1:0] c_sens_r, c_offset_r, c_sens_tc_r;
  logic [COEF_W-1:0] c_offset_tc_r, c_ref_temp_r, c_temp_slope_r;

  logic accept;
  logic [PIPE_LAT-1:0] vld_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_sens_r       <= '0;
      c_offset_r     <= '0;
      c_sens_tc_r    <= '0;
      c_offset_tc_r  <= '0;
      c_ref_temp_r   <= '0;
      c_temp_slope_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENS:       c_sens_r       <= cfg_data;
        REG_OFFSET:     c_offset_r     <= cfg_data;
        REG_SENS_TC:    c_sens_tc_r    <= cfg_data;
        REG_OFFSET_TC:  c_offset_tc_r  <= cfg_data;
        REG_REF_TEMP:   c_ref_temp_r   <= cfg_data;
        REG_TEMP_SLOPE: c_temp_slope_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The valid bits shift along with the data; nothing in the pipe ever waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], accept};
    end
  end

  // Stage 1: temperature difference to the reference, dT = D2 - C5 * 256.
  logic [RAW_W-1:0]        d1_s1_r;
  logic signed [DT_W-1:0]  dt_r;
  logic signed [DT_W-1:0]  dt_full;
  assign dt_full = $signed({2'b00, in_raw_temperature}) -
                   $signed({2'b00, c_ref_temp_r, 8'b0});

  // Stage 2: the four products that depend on dT alone.
  logic [RAW_W-1:0]          d1_s2_r;
  logic signed [PRD1_W-1:0]  mt_r, mo_r, ms_r, mt_nxt, mo_nxt, ms_nxt;
  logic signed [DD_W-1:0]    dd_r, dd_nxt;
  assign mt_nxt = PRD1_W'(dt_r) * PRD1_W'($signed({1'b0, c_temp_slope_r}));
  assign mo_nxt = PRD1_W'(dt_r) * PRD1_W'($signed({1'b0, c_offset_tc_r}));
  assign ms_nxt = PRD1_W'(dt_r) * PRD1_W'($signed({1'b0, c_sens_tc_r}));
  assign dd_nxt = DD_W'(dt_r) * DD_W'(dt_r);

  // Stage 3: first-order temperature, offset and sensitivity.
  logic [RAW_W-1:0]          d1_s3_r;
  logic signed [TEMP_W-1:0]  temp_s3_r, t2_r, temp_s3_nxt, t2_nxt;
  logic signed [WIDE_W-1:0]  off_s3_r, sens_s3_r, off_s3_nxt, sens_s3_nxt;
  assign temp_s3_nxt = T_REF + TEMP_W'(mt_r >>> 23);
  assign off_s3_nxt  = $signed({16'b0, c_offset_r, 16'b0}) + WIDE_W'(mo_r >>> 7);
  assign sens_s3_nxt = $signed({17'b0, c_sens_r, 15'b0}) + WIDE_W'(ms_r >>> 8);
  assign t2_nxt      = TEMP_W'(dd_r >>> 31);

  // Stage 4: region flags, squared distances to the break points and the
  // corrected temperature.
  logic [RAW_W-1:0]          d1_s4_r;
  logic signed [WIDE_W-1:0]  off_s4_r, sens_s4_r, sq_r, vsq_r, sq_nxt, vsq_nxt;
  logic signed [TEMP_W-1:0]  temp_fin_r, temp_fin_nxt, lo, vlo;
  logic                      lt20_r, ltm15_r, lt20_nxt, ltm15_nxt;
  assign lo           = temp_s3_r - T_REF;
  assign vlo          = temp_s3_r - T_COLD;
  assign sq_nxt       = WIDE_W'(lo) * WIDE_W'(lo);
  assign vsq_nxt      = WIDE_W'(vlo) * WIDE_W'(vlo);
  assign lt20_nxt     = temp_s3_r < T_REF;
  assign ltm15_nxt    = temp_s3_r < T_COLD;
  assign temp_fin_nxt = lt20_nxt ? (temp_s3_r - t2_r) : temp_s3_r;

  // Stage 5: second-order offset and sensitivity terms, built by shift and add.
  logic [RAW_W-1:0]          d1_s5_r;
  logic signed [WIDE_W-1:0]  off_s5_r, sens_s5_r, off2_r, sens2_r, off2_nxt, sens2_nxt;
  logic signed [TEMP_W-1:0]  temp_s5_r;
  logic signed [WIDE_W-1:0]  sq5, vsq7, vsq11;
  always_comb begin
    sq5       = (sq_r <<< 2) + sq_r;
    vsq7      = (vsq_r <<< 3) - vsq_r;
    vsq11     = (vsq_r <<< 3) + (vsq_r <<< 1) + vsq_r;
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (lt20_r) begin
      off2_nxt  = sq5 >>> 1;
      sens2_nxt = sq5 >>> 2;
      if (ltm15_r) begin
        off2_nxt  = off2_nxt + vsq7;
        sens2_nxt = sens2_nxt + (vsq11 >>> 1);
      end
    end
  end

  // Stage 6: corrected offset and sensitivity.
  logic [RAW_W-1:0]          d1_s6_r;
  logic signed [WIDE_W-1:0]  off_f_r, sens_f_r;
  logic signed [TEMP_W-1:0]  temp_s6_r;

  // Stage 7: D1 * SENS split into two partial products on the sensitivity.
  logic [PL_W-1:0]           pl_r, pl_nxt;
  logic signed [PH_W-1:0]    ph_r, ph_nxt;
  logic signed [WIDE_W-1:0]  off_s7_r;
  logic signed [TEMP_W-1:0]  temp_s7_r;
  assign pl_nxt = PL_W'(d1_s6_r) * PL_W'(sens_f_r[19:0]);
  assign ph_nxt = PH_W'($signed({1'b0, d1_s6_r})) * PH_W'($signed(sens_f_r[WIDE_W-1:20]));

  // Stage 8: recombine the partial products.
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [WIDE_W-1:0]  off_s8_r;
  logic signed [TEMP_W-1:0]  temp_s8_r;
  assign prod_nxt = (PROD_W'(ph_r) <<< 20) + $signed({20'b0, pl_r});

  // Stage 9: pressure = ((D1 * SENS >> 21) - OFF) >> 15, low 32 bits kept.
  logic signed [PROD_W-1:0]  p_full;
  logic signed [RES_W-1:0]   p_r, t_r;
  assign p_full = (prod_r >>> 21) - PROD_W'(off_s8_r);

  always_ff @(posedge clk) begin
    d1_s1_r    <= in_raw_pressure;
    dt_r       <= dt_full;

    d1_s2_r    <= d1_s1_r;
    mt_r       <= mt_nxt;
    mo_r       <= mo_nxt;
    ms_r       <= ms_nxt;
    dd_r       <= dd_nxt;

    d1_s3_r    <= d1_s2_r;
    temp_s3_r  <= temp_s3_nxt;
    off_s3_r   <= off_s3_nxt;
    sens_s3_r  <= sens_s3_nxt;
    t2_r       <= t2_nxt;

    d1_s4_r    <= d1_s3_r;
    off_s4_r   <= off_s3_r;
    sens_s4_r  <= sens_s3_r;
    sq_r       <= sq_nxt;
    vsq_r      <= vsq_nxt;
    lt20_r     <= lt20_nxt;
    ltm15_r    <= ltm15_nxt;
    temp_fin_r <= temp_fin_nxt;

    d1_s5_r    <= d1_s4_r;
    off_s5_r   <= off_s4_r;
    sens_s5_r  <= sens_s4_r;
    temp_s5_r  <= temp_fin_r;
    off2_r     <= off2_nxt;
    sens2_r    <= sens2_nxt;

    d1_s6_r    <= d1_s5_r;
    off_f_r    <= off_s5_r - off2_r;
    sens_f_r   <= sens_s5_r - sens2_r;
    temp_s6_r  <= temp_s5_r;

    pl_r       <= pl_nxt;
    ph_r       <= ph_nxt;
    off_s7_r   <= off_f_r;
    temp_s7_r  <= temp_s6_r;

    prod_r     <= prod_nxt;
    off_s8_r   <= off_s7_r;
    temp_s8_r  <= temp_s7_r;

    p_r        <= RES_W'(p_full >>> 15);
    t_r        <= RES_W'(temp_s8_r);
  end

  assign out_valid                 = vld_r[PIPE_LAT-1];
  assign out_pressure_centi_mbar   = p_r;
  assign out_temperature_centi_deg = t_r;

`ifndef SYNTHESIS
  // Every accepted request yields exactly one strobe, when its valid bit leaves the shift register.
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(PIPE_LAT) out_valid)
    else $error("accepted request produced no result strobe");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result strobe without a matching request");

  // The cold branch is only reachable inside the low-temperature branch.
  a_cold_in_low: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && ltm15_r |-> lt20_r)
    else $error("cold correction flagged above 20 degrees");

  // At or above 20 degrees the second-order terms must vanish.
  a_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !$past(lt20_r) |-> off2_r == '0 && sens2_r == '0)
    else $error("second-order correction applied above 20 degrees");
`endif

endmodule
